/* design/rgbe_rle_pkg.sv */
// Shared constants and the span operation word passed from front to back of the RGBE decoder.
package rgbe_rle_pkg;

	localparam int unsigned MAX_WIDTH     = 32767;
	localparam int unsigned MIN_RLE_WIDTH = 8;

	localparam logic [7:0] HDR_MARK = 8'h02;
	localparam logic [7:0] RUN_CODE = 8'h80;

	localparam logic [1:0] ST_OK             = 2'd0;
	localparam logic [1:0] ST_WIDTH_MISMATCH = 2'd1;
	localparam logic [1:0] ST_OVERRUN        = 2'd2;

	localparam logic [1:0] LAST_SUB = 2'd3;

	// one queued operation: a single span, or four flat bytes from a rejected header
	typedef struct packed {
		logic            flat4;
		logic [1:0]      channel;
		logic [14:0]     start_pos;
		logic [7:0]      span_len;
		logic [7:0]      span_value;
		logic [1:0]      status;
		logic            line_done;
		logic [2:0][7:0] tail_bytes;
	} span_op_t;

endpackage

/* design/rgbe_rle_front.sv */
// Front end: byte acceptance, header check and scanline state, at most one span operation per byte.
module rgbe_rle_front import rgbe_rle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [14:0] line_width,
	input  logic [7:0]  in_byte,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        push,
	output span_op_t    push_op,
	input  logic        q_ready
);

	typedef enum logic [4:0] {
		PH_HDR  = 5'b00001,
		PH_FLAT = 5'b00010,
		PH_CODE = 5'b00100,
		PH_RUNV = 5'b01000,
		PH_LIT  = 5'b10000
	} phase_t;

	phase_t      phase_q, n_phase;
	logic [7:0]  held_q [3];
	logic [1:0]  held_count_q, n_held_count;
	logic [1:0]  plane_q, n_plane;
	logic [14:0] pixel_pos_q, n_pixel;
	logic [7:0]  literal_left_q, n_ll;
	logic [6:0]  run_len_q, n_run;
	logic [16:0] flat_count_q, n_flat;

	logic        accept, emit, hold_wr, go_hdr, do_flat, do_pc;
	logic [14:0] w, pc_pos, hdr_width, run_end, lit_end;
	logic        rle_w, flat_done, is_run, overrun, hdr_ok;
	logic [16:0] w4, fc_inc;
	logic [7:0]  code_len, ll_dec;
	logic [15:0] code_end;

	assign in_ready = q_ready;
	assign accept   = in_valid & q_ready;
	assign push     = accept & emit;

	assign w         = (line_width == 15'd0) ? 15'd1 : line_width;
	assign rle_w     = (w >= 15'(MIN_RLE_WIDTH)) && (w <= 15'(MAX_WIDTH));
	assign w4        = {w, 2'b00};
	assign fc_inc    = flat_count_q + 17'd1;
	assign flat_done = fc_inc >= w4;
	assign is_run    = in_byte > RUN_CODE;
	assign code_len  = is_run ? {1'b0, in_byte[6:0]} : in_byte;
	assign code_end  = {1'b0, pixel_pos_q} + {8'd0, code_len};
	assign overrun   = code_end > {1'b0, w};
	assign hdr_ok    = rle_w && (held_q[0] == HDR_MARK) && (held_q[1] == HDR_MARK) &&
	                   !held_q[2][7];
	assign hdr_width = {held_q[2][6:0], in_byte};
	assign run_end   = pixel_pos_q + {8'd0, run_len_q};
	assign lit_end   = pixel_pos_q + 15'd1;
	assign ll_dec    = (literal_left_q != 8'd0) ? literal_left_q - 8'd1 : 8'd0;

	always_comb begin
		n_phase      = phase_q;
		n_held_count = held_count_q;
		n_plane      = plane_q;
		n_pixel      = pixel_pos_q;
		n_ll         = literal_left_q;
		n_run        = run_len_q;
		n_flat       = flat_count_q;
		emit         = 1'b0;
		hold_wr      = 1'b0;
		go_hdr       = 1'b0;
		do_flat      = 1'b0;
		do_pc        = 1'b0;
		pc_pos       = pixel_pos_q;
		push_op      = '0;

		unique case (phase_q)
			PH_HDR: begin
				if (held_count_q == 2'd0 && !rle_w) begin
					do_flat = 1'b1;
				end else if (held_count_q != 2'd3) begin
					hold_wr      = 1'b1;
					n_held_count = held_count_q + 2'd1;
				end else begin
					n_held_count = 2'd0;
					if (hdr_ok) begin
						if (hdr_width != w) begin
							emit              = 1'b1;
							push_op.channel   = plane_q;
							push_op.start_pos = pixel_pos_q;
							push_op.status    = ST_WIDTH_MISMATCH;
							push_op.line_done = 1'b1;
							go_hdr            = 1'b1;
						end else begin
							n_plane = 2'd0;
							n_pixel = 15'd0;
							n_phase = PH_CODE;
						end
					end else begin
						// rejected header: the three held bytes and the current byte are flat bytes 0..3
						emit               = 1'b1;
						push_op.flat4      = 1'b1;
						push_op.span_len   = 8'd1;
						push_op.span_value = held_q[0];
						push_op.tail_bytes = {in_byte, held_q[2], held_q[1]};
						push_op.status     = ST_OK;
						push_op.line_done  = (w == 15'd1);
						if (w == 15'd1) begin
							go_hdr = 1'b1;
						end else begin
							n_phase = PH_FLAT;
							n_flat  = 17'd4;
						end
					end
				end
			end
			PH_FLAT: begin
				do_flat = 1'b1;
			end
			PH_CODE: begin
				if (in_byte == 8'd0) begin
					n_phase = PH_CODE;
				end else if (overrun) begin
					emit              = 1'b1;
					push_op.channel   = plane_q;
					push_op.start_pos = pixel_pos_q;
					push_op.status    = ST_OVERRUN;
					push_op.line_done = 1'b1;
					go_hdr            = 1'b1;
				end else if (is_run) begin
					n_run   = in_byte[6:0];
					n_phase = PH_RUNV;
				end else begin
					n_ll    = in_byte;
					n_phase = PH_LIT;
				end
			end
			PH_RUNV: begin
				emit               = 1'b1;
				push_op.channel    = plane_q;
				push_op.start_pos  = pixel_pos_q;
				push_op.span_len   = {1'b0, run_len_q};
				push_op.span_value = in_byte;
				push_op.status     = ST_OK;
				do_pc              = 1'b1;
				pc_pos             = run_end;
			end
			PH_LIT: begin
				emit               = 1'b1;
				push_op.channel    = plane_q;
				push_op.start_pos  = pixel_pos_q;
				push_op.span_len   = 8'd1;
				push_op.span_value = in_byte;
				push_op.status     = ST_OK;
				n_ll               = ll_dec;
				if (ll_dec == 8'd0 || lit_end >= w) begin
					do_pc  = 1'b1;
					pc_pos = lit_end;
				end else begin
					n_pixel = lit_end;
				end
			end
			default: begin
				go_hdr = 1'b1;
			end
		endcase

		if (do_flat) begin
			emit               = 1'b1;
			push_op.channel    = flat_count_q[1:0];
			push_op.start_pos  = flat_count_q[16:2];
			push_op.span_len   = 8'd1;
			push_op.span_value = in_byte;
			push_op.status     = ST_OK;
			push_op.line_done  = flat_done;
			if (flat_done) begin
				go_hdr = 1'b1;
			end else begin
				n_phase = PH_FLAT;
				n_flat  = fc_inc;
			end
		end

		// span end: continue the plane, move to the next plane, or end the line after the exponent plane
		if (do_pc) begin
			if (pc_pos < w) begin
				n_phase = PH_CODE;
				n_pixel = pc_pos;
			end else if (plane_q == 2'd3) begin
				go_hdr            = 1'b1;
				push_op.line_done = 1'b1;
			end else begin
				n_plane = plane_q + 2'd1;
				n_pixel = 15'd0;
				n_ll    = 8'd0;
				n_phase = PH_CODE;
			end
		end

		if (go_hdr) begin
			n_phase      = PH_HDR;
			n_held_count = 2'd0;
			n_plane      = 2'd0;
			n_pixel      = 15'd0;
			n_ll         = 8'd0;
			n_run        = 7'd0;
			n_flat       = 17'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HDR;
			held_count_q   <= 2'd0;
			plane_q        <= 2'd0;
			pixel_pos_q    <= 15'd0;
			literal_left_q <= 8'd0;
			run_len_q      <= 7'd0;
			flat_count_q   <= 17'd0;
		end else if (accept) begin
			phase_q        <= n_phase;
			held_count_q   <= n_held_count;
			plane_q        <= n_plane;
			pixel_pos_q    <= n_pixel;
			literal_left_q <= n_ll;
			run_len_q      <= n_run;
			flat_count_q   <= n_flat;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_wr) begin
			held_q[held_count_q] <= in_byte;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(held_count_q != 2'd0) |-> (phase_q == PH_HDR))
		else $error("header bytes held outside header wait");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LIT) |-> (literal_left_q != 8'd0))
		else $error("literal phase with no literal bytes left");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RUNV) |-> (run_len_q != 7'd0))
		else $error("run value phase with empty run");

endmodule

/* design/rgbe_rle_fifo.sv */
// Short queue of span operations between the front and back ends.
module rgbe_rle_fifo import rgbe_rle_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  span_op_t push_op,
	output logic     push_ready,
	input  logic     pop,
	output span_op_t head,
	output logic     head_valid
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	span_op_t        mem [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_ready)
		else $error("operation pushed into a full queue");

endmodule

/* design/rgbe_rle_back.sv */
// Back end: expands queued operations into result words behind an output register.
module rgbe_rle_back import rgbe_rle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  span_op_t    head,
	input  logic        head_valid,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // channel[1:0] start_pos[16:2] span_len[24:17]
	                                   // span_value[32:25] last[33] zero[39:34]
	output logic        m_axis_tlast,  // line_done
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	logic        out_valid_q;
	logic [1:0]  sub_q;
	logic [1:0]  ch_q, st_q;
	logic [14:0] start_q;
	logic [7:0]  len_q, val_q;
	logic        done_q, last_q;

	logic        load, take, sub_last;
	logic [1:0]  ch_d;
	logic [7:0]  val_d;

	assign load     = !out_valid_q || m_axis_tready;
	assign take     = load && head_valid;
	assign sub_last = !head.flat4 || (sub_q == LAST_SUB);
	assign pop      = take && sub_last;

	always_comb begin
		ch_d  = head.channel;
		val_d = head.span_value;
		if (head.flat4) begin
			ch_d = sub_q;
			if (sub_q != 2'd0) begin
				val_d = head.tail_bytes[sub_q - 2'd1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 2'd0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (take) begin
				sub_q <= sub_last ? 2'd0 : sub_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ch_q    <= ch_d;
			start_q <= head.start_pos;
			len_q   <= head.span_len;
			val_q   <= val_d;
			st_q    <= head.status;
			done_q  <= head.line_done && sub_last;
			last_q  <= sub_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, last_q, val_q, len_q, start_q, ch_q};
	assign m_axis_tlast  = done_q;
	assign m_axis_tuser  = st_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(sub_q != 2'd0) |-> (head_valid && head.flat4))
		else $error("flat expansion in progress without a flat operation at head");

endmodule

/* design/rgbe_scanline_rle_decoder_unit.sv */
// Top level of the RGBE scanline run-length decoder.
// Takes one encoded byte per cycle on s_axis while the queue has room and gives spans on
// m_axis. Each byte is classified in the cycle it is accepted (header check, run and literal
// codes, flat pixels) and its result word, if any, enters a queue of QUEUE_DEPTH operations;
// the output side delivers one word per cycle while m_axis_tready is high, behind its own
// register. A rejected header is one queued operation that yields four words, and input
// stalls only when the queue is full. The line width register is written on the cfg channel,
// which is always ready, and takes effect for the next byte; a zero width acts as one.
module rgbe_scanline_rle_decoder_unit import rgbe_rle_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data,      // line_width
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // in_byte[7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // channel[1:0] start_pos[16:2] span_len[24:17]
	                                   // span_value[32:25] last[33] zero[39:34]
	output logic        m_axis_tlast,  // line_done
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	logic [14:0] line_width_q;
	logic        push, push_ready, pop, head_valid;
	span_op_t    push_op, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= 15'd1;
		end else if (cfg_valid) begin
			line_width_q <= cfg_data;
		end
	end

	rgbe_rle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_width (line_width_q),
		.in_byte    (s_axis_tdata),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.push       (push),
		.push_op    (push_op),
		.q_ready    (push_ready)
	);

	rgbe_rle_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.push_ready (push_ready),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	rgbe_rle_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
